// ===== sv/gic_pkg.sv =====
// Shared types and constants for the gamepad input conditioner.
package gic_pkg;

    // Pad type codes
    localparam logic [7:0] KIND_DIGITAL = 8'h41;
    localparam logic [7:0] KIND_ANALOG  = 8'h23;
    localparam logic [7:0] KIND_NONE    = 8'h00;

    // Fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_LINK  = 2'd1;
    localparam logic [1:0] FAULT_ABORT = 2'd2;

    localparam logic [7:0] STATUS_UNUSABLE = 8'd1;

    // Fault hold and suppression
    localparam logic [5:0] HOLD_RELOAD  = 6'h22;
    localparam logic [4:0] SUPPRESS_SET = 5'h10;

    // Abort combinations on the raw held mask
    localparam logic [15:0] ABORT_PAIR_A = 16'h5000;
    localparam logic [15:0] ABORT_PAIR_B = 16'hA000;
    localparam logic [15:0] ABORT_ANY    = 16'h01C4;

    // Button bits
    localparam logic [15:0] BTN_RIGHT    = 16'h2000;
    localparam logic [15:0] BTN_LEFT     = 16'h8000;
    localparam logic [15:0] BTN_FIRST    = 16'h0040;
    localparam logic [15:0] BTN_SECOND   = 16'h0080;
    localparam logic [15:0] BTN_SHOULDER = 16'h0004;

    // Levels and thresholds
    localparam logic [7:0] LEVEL_MAX      = 8'h6A;
    localparam logic [7:0] LEVEL_THRESH   = 8'h36;
    localparam logic [7:0] STEER_CENTRE   = 8'h80;
    localparam logic [7:0] STEER_RIGHT_TH = 8'hA3;
    localparam logic [7:0] STEER_LEFT_TH  = 8'h5E;

    // Auto-repeat counter
    localparam logic [5:0] REPEAT_FIRE = 6'h1E;
    localparam logic [5:0] REPEAT_TOP  = 6'h24;

    localparam logic [6:0] STEER_LIMIT_RESET = 7'd127;

    typedef enum logic [2:0] {
        CFG_NEUTRAL_FIRST    = 3'd0,
        CFG_NEUTRAL_SECOND   = 3'd1,
        CFG_NEUTRAL_SHOULDER = 3'd2,
        CFG_STEER_OFFSET     = 3'd3,
        CFG_STEER_DEADZONE   = 3'd4,
        CFG_STEER_LIMIT      = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]        neutral_first;
        logic [7:0]        neutral_second;
        logic [7:0]        neutral_shoulder;
        logic signed [7:0] steer_center_offset;
        logic [6:0]        steer_deadzone;
        logic [6:0]        steer_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] link_status;
        logic [7:0] pad_kind;
        logic [7:0] buttons_high;
        logic [7:0] buttons_low;
        logic [7:0] steer_raw;
        logic [7:0] analog_first;
        logic [7:0] analog_second;
        logic [7:0] analog_shoulder;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]        status_out;
        logic [15:0]       held_buttons;
        logic [15:0]       new_buttons;
        logic [15:0]       pressed_buttons;
        logic [7:0]        steer_level;
        logic [6:0]        level_first;
        logic [6:0]        level_second;
        logic [6:0]        level_shoulder;
        logic signed [7:0] steer_signed;
        logic [1:0]        fault_code;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] previous_held;
        logic [5:0]  repeat_count;
        logic [5:0]  fault_hold_count;
        logic [4:0]  suppress_shifter;
        logic [1:0]  fault_latch;
    } t_state;

endpackage

// ===== sv/gic_frame.sv =====
// Per-frame conditioning logic: result beat and next state from one poll frame.
module gic_frame (
    input  gic_pkg::t_in_beat  i_beat,
    input  gic_pkg::t_cfg      i_cfg,
    input  gic_pkg::t_state    i_state,
    output gic_pkg::t_out_beat o_beat,
    output gic_pkg::t_state    o_state
);

    logic [15:0]       raw_held;
    logic              abort_combo;
    logic [1:0]        fl;
    logic [5:0]        hc;
    logic [4:0]        sh;
    logic [7:0]        kind;
    logic [7:0]        status;
    logic [15:0]       held;
    logic [15:0]       newb;
    logic [15:0]       pressed;
    logic [5:0]        rc;
    logic [7:0]        steer;
    logic [7:0]        l1, l2, l3;
    logic [7:0]        d1, d2, d3;
    logic signed [9:0] centre;
    logic signed [9:0] d;
    logic signed [9:0] r;
    logic signed [9:0] dz;
    logic signed [9:0] lim;

    always_comb begin
        raw_held    = ~{i_beat.buttons_high, i_beat.buttons_low};
        abort_combo = ((raw_held & gic_pkg::ABORT_PAIR_A) == gic_pkg::ABORT_PAIR_A) ||
                      ((raw_held & gic_pkg::ABORT_PAIR_B) == gic_pkg::ABORT_PAIR_B) ||
                      ((raw_held & gic_pkg::ABORT_ANY) != 16'd0);

        // fault latching
        fl = i_state.fault_latch;
        hc = i_state.fault_hold_count;
        sh = i_state.suppress_shifter;
        if (i_beat.link_status != 8'd0) begin
            fl = gic_pkg::FAULT_LINK;
            hc = gic_pkg::HOLD_RELOAD;
            sh = sh | gic_pkg::SUPPRESS_SET;
        end else if (hc != 6'd0) begin
            hc = hc - 6'd1;
            if (i_beat.pad_kind == gic_pkg::KIND_ANALOG && abort_combo) begin
                fl = gic_pkg::FAULT_ABORT;
                hc = gic_pkg::HOLD_RELOAD;
                sh = sh | gic_pkg::SUPPRESS_SET;
            end
        end
        sh   = sh >> 1;
        kind = i_beat.pad_kind;
        if (sh != 5'd0) begin
            kind = gic_pkg::KIND_NONE;
        end else begin
            fl = gic_pkg::FAULT_NONE;
        end

        // analog channels less neutral, floored at zero
        d1 = (i_beat.analog_first >= i_cfg.neutral_first) ?
             i_beat.analog_first - i_cfg.neutral_first : 8'd0;
        d2 = (i_beat.analog_second >= i_cfg.neutral_second) ?
             i_beat.analog_second - i_cfg.neutral_second : 8'd0;
        d3 = (i_beat.analog_shoulder >= i_cfg.neutral_shoulder) ?
             i_beat.analog_shoulder - i_cfg.neutral_shoulder : 8'd0;

        status = i_beat.link_status;
        if (kind == gic_pkg::KIND_DIGITAL) begin
            held  = raw_held;
            steer = gic_pkg::STEER_CENTRE;
            if ((held & gic_pkg::BTN_LEFT) != 16'd0) begin
                if ((held & gic_pkg::BTN_RIGHT) == 16'd0) begin
                    steer = gic_pkg::STEER_CENTRE - {1'b0, i_cfg.steer_limit};
                end
            end else if ((held & gic_pkg::BTN_RIGHT) != 16'd0) begin
                steer = gic_pkg::STEER_CENTRE + {1'b0, i_cfg.steer_limit};
            end
            l1 = ((held & gic_pkg::BTN_FIRST) != 16'd0) ? gic_pkg::LEVEL_MAX : 8'd0;
            l2 = ((held & gic_pkg::BTN_SECOND) != 16'd0) ? gic_pkg::LEVEL_MAX : 8'd0;
            l3 = ((held & gic_pkg::BTN_SHOULDER) != 16'd0) ? gic_pkg::LEVEL_MAX : 8'd0;
            newb = held & ~i_state.previous_held;
        end else if (kind == gic_pkg::KIND_ANALOG) begin
            held  = raw_held;
            steer = i_beat.steer_raw;
            l1 = d1;
            l2 = d2;
            l3 = d3;
            if (steer >= gic_pkg::STEER_RIGHT_TH) held = held | gic_pkg::BTN_RIGHT;
            if (steer < gic_pkg::STEER_LEFT_TH)   held = held | gic_pkg::BTN_LEFT;
            if (l1 >= gic_pkg::LEVEL_THRESH)      held = held | gic_pkg::BTN_FIRST;
            if (l2 >= gic_pkg::LEVEL_THRESH)      held = held | gic_pkg::BTN_SECOND;
            if (l3 >= gic_pkg::LEVEL_THRESH)      held = held | gic_pkg::BTN_SHOULDER;
            newb = held & ~i_state.previous_held;
        end else begin
            if (fl == gic_pkg::FAULT_NONE) fl = gic_pkg::FAULT_ABORT;
            status = gic_pkg::STATUS_UNUSABLE;
            held   = 16'd0;
            newb   = 16'd0;
            steer  = gic_pkg::STEER_CENTRE;
            l1 = 8'd0;
            l2 = 8'd0;
            l3 = 8'd0;
        end

        // new presses plus auto-repeat
        pressed = held & ~i_state.previous_held;
        rc      = 6'd0;
        if (held != 16'd0 && held == i_state.previous_held) begin
            if (i_state.repeat_count == gic_pkg::REPEAT_FIRE) pressed = pressed | held;
            rc = (i_state.repeat_count < gic_pkg::REPEAT_TOP) ?
                 i_state.repeat_count + 6'd1 : gic_pkg::REPEAT_FIRE;
        end

        // steering: centre offset, deadzone, limit
        centre = 10'sd128 + {{2{i_cfg.steer_center_offset[7]}}, i_cfg.steer_center_offset};
        dz     = {3'b000, i_cfg.steer_deadzone};
        lim    = {3'b000, i_cfg.steer_limit};
        d      = $signed({2'b00, steer}) - centre;
        if (d > 10'sd0) begin
            r = d - dz;
            if (r < 10'sd0) r = 10'sd0;
            if (r > lim)    r = lim;
        end else begin
            r = d + dz;
            if (r > 10'sd0) r = 10'sd0;
            if (r < -lim)   r = -lim;
        end

        o_beat.status_out      = status;
        o_beat.held_buttons    = held;
        o_beat.new_buttons     = newb;
        o_beat.pressed_buttons = pressed;
        o_beat.steer_level     = steer;
        o_beat.level_first     = (l1 > gic_pkg::LEVEL_MAX) ? gic_pkg::LEVEL_MAX[6:0] : l1[6:0];
        o_beat.level_second    = (l2 > gic_pkg::LEVEL_MAX) ? gic_pkg::LEVEL_MAX[6:0] : l2[6:0];
        o_beat.level_shoulder  = (l3 > gic_pkg::LEVEL_MAX) ? gic_pkg::LEVEL_MAX[6:0] : l3[6:0];
        o_beat.steer_signed    = r[7:0];
        o_beat.fault_code      = fl;

        o_state.previous_held    = held;
        o_state.repeat_count     = rc;
        o_state.fault_hold_count = hc;
        o_state.suppress_shifter = sh;
        o_state.fault_latch      = fl;
    end

endmodule

// ===== sv/gamepad_input_conditioner.sv =====
// Top level: config registers, frame state and two-entry output buffer.
// An accepted poll frame's result is registered into the main entry (driving o_out_*) or the skid entry under stall.
// Throughput: one beat per cycle unless stalled; all work is one frame-logic pass before the result register.
// A second result register (skid entry) lets an input beat in while one result waits;
// input ready drops only when both entries are full.
// Reset (synchronous, active low): frame state and buffer valid flags cleared, config to defaults
// (neutrals, offset and deadzone 0, steering limit 127).
module gamepad_input_conditioner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // poll frame in
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gic_pkg::t_in_beat   i_in_beat,
    // result out
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gic_pkg::t_out_beat  o_out_beat,
    // config writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    gic_pkg::t_cfg      r_cfg, n_cfg;
    gic_pkg::t_state    r_state;
    gic_pkg::t_state    frame_state;
    gic_pkg::t_out_beat frame_beat;

    // output buffer: main entry drives the port, skid entry catches a beat under stall
    gic_pkg::t_out_beat r_out, n_out;
    gic_pkg::t_out_beat r_skid, n_skid;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;

    logic in_accept;
    logic out_fire;

    assign o_in_ready  = !r_skid_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_cfg_ready = 1'b1;

    gic_frame u_frame (
        .i_beat  (i_in_beat),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_beat  (frame_beat),
        .o_state (frame_state)
    );

    // config register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (gic_pkg::t_cfg_index'(i_cfg_index))
                gic_pkg::CFG_NEUTRAL_FIRST:    n_cfg.neutral_first       = i_cfg_data;
                gic_pkg::CFG_NEUTRAL_SECOND:   n_cfg.neutral_second      = i_cfg_data;
                gic_pkg::CFG_NEUTRAL_SHOULDER: n_cfg.neutral_shoulder    = i_cfg_data;
                gic_pkg::CFG_STEER_OFFSET:     n_cfg.steer_center_offset = i_cfg_data;
                gic_pkg::CFG_STEER_DEADZONE:   n_cfg.steer_deadzone      = i_cfg_data[6:0];
                gic_pkg::CFG_STEER_LIMIT:      n_cfg.steer_limit         = i_cfg_data[6:0];
                default:                       n_cfg = r_cfg;   // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_first       <= 8'd0;
            r_cfg.neutral_second      <= 8'd0;
            r_cfg.neutral_shoulder    <= 8'd0;
            r_cfg.steer_center_offset <= 8'sd0;
            r_cfg.steer_deadzone      <= 7'd0;
            r_cfg.steer_limit         <= gic_pkg::STEER_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // frame state advances once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= frame_state;
        end
    end

    // output buffer control
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_accept) begin
                n_out       = frame_beat;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_accept) begin
            // main entry stalled: park the beat
            n_skid       = frame_beat;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the gamepad input conditioner: predicts each result beat and compares.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gic_pkg::*;

    // Longest legal spell without any beat: well above the receiver hold-off
    localparam int HOLD_OFF    = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 235;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the frame state and the config registers,
    // the conditioned results still owed by the block, and the checker.
    // ------------------------------------------------------------------
    class frame_checker;
        t_cfg        cfg;
        logic [15:0] prev_held;
        logic [5:0]  repeat_cnt;
        logic [5:0]  hold_cnt;
        logic [4:0]  mute_shift;
        logic [1:0]  fault_state;
        t_out_beat   owed_q[$];
        int          mismatches;
        int          checked;

        function new();
            cfg             = '0;
            cfg.steer_limit = STEER_LIMIT_RESET;
            prev_held       = '0;
            repeat_cnt      = '0;
            hold_cnt        = '0;
            mute_shift      = '0;
            fault_state     = FAULT_NONE;
            mismatches      = 0;
            checked         = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(string what);
            $display("MISMATCH beat %0d: %s", checked, what);
            mismatches++;
        endtask

        function void set_reg(t_cfg_index idx, logic [7:0] data);
            case (idx)
                CFG_NEUTRAL_FIRST:    cfg.neutral_first       = data;
                CFG_NEUTRAL_SECOND:   cfg.neutral_second      = data;
                CFG_NEUTRAL_SHOULDER: cfg.neutral_shoulder    = data;
                CFG_STEER_OFFSET:     cfg.steer_center_offset = data;
                CFG_STEER_DEADZONE:   cfg.steer_deadzone      = data[6:0];
                CFG_STEER_LIMIT:      cfg.steer_limit         = data[6:0];
                default: ;
            endcase
        endfunction

        // One poll frame through the conditioning, updating the frame state
        function t_out_beat condition_frame(t_in_beat f);
            t_out_beat   r;
            logic [7:0]  kind;
            logic [15:0] raw;
            logic [15:0] held;
            logic [15:0] fresh;
            logic [15:0] pressed;
            int          steer;
            int          lv1;
            int          lv2;
            int          lv3;
            int          dev;
            int          trim;
            int          dz;
            int          lim;
            kind         = f.pad_kind;
            raw          = ~{f.buttons_high, f.buttons_low};
            r.status_out = f.link_status;
            dz           = int'(cfg.steer_deadzone);
            lim          = int'(cfg.steer_limit);

            // fault latching: link error first, abort combination only while holding
            if (f.link_status != 8'd0) begin
                fault_state = FAULT_LINK;
                hold_cnt    = HOLD_RELOAD;
                mute_shift  = mute_shift | SUPPRESS_SET;
            end else if (hold_cnt != 6'd0) begin
                hold_cnt = hold_cnt - 6'd1;
                if (kind == KIND_ANALOG &&
                    (((raw & ABORT_PAIR_A) == ABORT_PAIR_A) ||
                     ((raw & ABORT_PAIR_B) == ABORT_PAIR_B) ||
                     ((raw & ABORT_ANY) != 16'd0))) begin
                    fault_state = FAULT_ABORT;
                    hold_cnt    = HOLD_RELOAD;
                    mute_shift  = mute_shift | SUPPRESS_SET;
                end
            end
            mute_shift = mute_shift >> 1;
            if (mute_shift != 5'd0) kind = KIND_NONE;
            else fault_state = FAULT_NONE;

            if (kind == KIND_DIGITAL) begin
                held  = raw;
                steer = int'(STEER_CENTRE);
                if ((held & BTN_LEFT) != 16'd0) begin
                    if ((held & BTN_RIGHT) == 16'd0) steer = int'(STEER_CENTRE) - lim;
                end else if ((held & BTN_RIGHT) != 16'd0) begin
                    steer = int'(STEER_CENTRE) + lim;
                end
                lv1 = ((held & BTN_FIRST) != 16'd0) ? int'(LEVEL_MAX) : 0;
                lv2 = ((held & BTN_SECOND) != 16'd0) ? int'(LEVEL_MAX) : 0;
                lv3 = ((held & BTN_SHOULDER) != 16'd0) ? int'(LEVEL_MAX) : 0;
            end else if (kind == KIND_ANALOG) begin
                held  = raw;
                steer = int'(f.steer_raw);
                lv1   = int'(f.analog_first) - int'(cfg.neutral_first);
                lv2   = int'(f.analog_second) - int'(cfg.neutral_second);
                lv3   = int'(f.analog_shoulder) - int'(cfg.neutral_shoulder);
                if (lv1 < 0) lv1 = 0;
                if (lv2 < 0) lv2 = 0;
                if (lv3 < 0) lv3 = 0;
                if (steer >= int'(STEER_RIGHT_TH)) held = held | BTN_RIGHT;
                if (steer < int'(STEER_LEFT_TH)) held = held | BTN_LEFT;
                if (lv1 >= int'(LEVEL_THRESH)) held = held | BTN_FIRST;
                if (lv2 >= int'(LEVEL_THRESH)) held = held | BTN_SECOND;
                if (lv3 >= int'(LEVEL_THRESH)) held = held | BTN_SHOULDER;
            end else begin
                // unusable pad: disconnected defaults
                if (fault_state == FAULT_NONE) fault_state = FAULT_ABORT;
                r.status_out = STATUS_UNUSABLE;
                held  = '0;
                steer = int'(STEER_CENTRE);
                lv1   = 0;
                lv2   = 0;
                lv3   = 0;
            end

            fresh   = held & ~prev_held;
            pressed = fresh;
            if (held != 16'd0 && held == prev_held) begin
                if (repeat_cnt == REPEAT_FIRE) pressed = pressed | held;
                repeat_cnt = (repeat_cnt < REPEAT_TOP) ? repeat_cnt + 6'd1 : REPEAT_FIRE;
            end else begin
                repeat_cnt = '0;
            end
            prev_held = held;

            dev = steer - (int'($signed(cfg.steer_center_offset)) + int'(STEER_CENTRE));
            if (dev > 0) begin
                trim = dev - dz;
                if (trim < 0) trim = 0;
                if (trim > lim) trim = lim;
            end else begin
                trim = dev + dz;
                if (trim > 0) trim = 0;
                if (trim < -lim) trim = -lim;
            end

            if (lv1 > int'(LEVEL_MAX)) lv1 = int'(LEVEL_MAX);
            if (lv2 > int'(LEVEL_MAX)) lv2 = int'(LEVEL_MAX);
            if (lv3 > int'(LEVEL_MAX)) lv3 = int'(LEVEL_MAX);

            r.held_buttons    = held;
            r.new_buttons     = fresh;
            r.pressed_buttons = pressed;
            r.steer_level     = steer[7:0];
            r.level_first     = lv1[6:0];
            r.level_second    = lv2[6:0];
            r.level_shoulder  = lv3[6:0];
            r.steer_signed    = trim[7:0];
            r.fault_code      = fault_state;
            return r;
        endfunction

        function void note_frame(t_in_beat f);
            owed_q.push_back(condition_frame(f));
        endfunction

        task field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            if (owed_q.size() == 0) begin
                report("result beat with nothing outstanding");
            end else begin
                want = owed_q.pop_front();
                field("status_out", got.status_out, want.status_out);
                field("held_buttons", got.held_buttons, want.held_buttons);
                field("new_buttons", got.new_buttons, want.new_buttons);
                field("pressed_buttons", got.pressed_buttons, want.pressed_buttons);
                field("steer_level", got.steer_level, want.steer_level);
                field("level_first", got.level_first, want.level_first);
                field("level_second", got.level_second, want.level_second);
                field("level_shoulder", got.level_shoulder, want.level_shoulder);
                field("steer_signed", got.steer_signed, want.steer_signed);
                field("fault_code", got.fault_code, want.fault_code);
            end
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and its stimulus signals; all driven to known values at time 0
    // ------------------------------------------------------------------
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_beat   in_beat   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_beat  o_out_beat;
    logic       o_cfg_ready;

    // pressure controls shared by the sender, the receiver and the main sequence
    logic       no_idle   = 1'b0;
    logic       long_hold = 1'b0;

    frame_checker sb;
    int           quiet;

    gamepad_input_conditioner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: counts cycles in which no beat moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------
    function automatic t_in_beat poll_frame(logic [7:0] link, logic [7:0] kind,
                                            logic [7:0] bh, logic [7:0] bl, logic [7:0] st,
                                            logic [7:0] a1, logic [7:0] a2, logic [7:0] a3);
        t_in_beat f;
        f.link_status     = link;
        f.pad_kind        = kind;
        f.buttons_high    = bh;
        f.buttons_low     = bl;
        f.steer_raw       = st;
        f.analog_first    = a1;
        f.analog_second   = a2;
        f.analog_shoulder = a3;
        return f;
    endfunction

    function automatic logic [7:0] rbyte();
        return 8'($urandom_range(0, 255));
    endfunction

    // a byte within a few counts of a boundary, clipped to the byte range
    function automatic logic [7:0] near_byte(int centre);
        int v;
        v = centre + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // pressure channel biased towards its button threshold, its clamp and its rest level
    function automatic logic [7:0] pressure_byte(logic [7:0] neutral);
        case ($urandom_range(0, 3))
            0: return near_byte(int'(neutral) + int'(LEVEL_THRESH));
            1: return near_byte(int'(neutral) + int'(LEVEL_MAX));
            2: return near_byte(int'(neutral));
            default: return rbyte();
        endcase
    endfunction

    // twist byte biased towards the button thresholds and the deadzone edges
    function automatic logic [7:0] twist_byte();
        int centre;
        centre = int'(STEER_CENTRE) + int'($signed(sb.cfg.steer_center_offset));
        case ($urandom_range(0, 4))
            0: return near_byte(int'(STEER_RIGHT_TH));
            1: return near_byte(int'(STEER_LEFT_TH));
            2: return near_byte(centre + int'(sb.cfg.steer_deadzone));
            3: return near_byte(centre - int'(sb.cfg.steer_deadzone));
            default: return rbyte();
        endcase
    endfunction

    function automatic t_in_beat random_frame();
        t_in_beat f;
        int       roll;
        f = poll_frame(8'd0, KIND_DIGITAL, rbyte(), rbyte(), twist_byte(),
                       pressure_byte(sb.cfg.neutral_first),
                       pressure_byte(sb.cfg.neutral_second),
                       pressure_byte(sb.cfg.neutral_shoulder));
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            f.link_status = 8'($urandom_range(1, 255));
            f.pad_kind    = rbyte();
        end else if (roll < 8) begin
            do f.pad_kind = rbyte();
            while (f.pad_kind == KIND_DIGITAL || f.pad_kind == KIND_ANALOG);
        end else if (roll >= 50) begin
            f.pad_kind = KIND_ANALOG;
            // mostly keep clear of the abort buttons so the hold window sees clean frames
            if ($urandom_range(0, 9) < 6) begin
                f.buttons_low  = f.buttons_low | 8'hC4;
                f.buttons_high = f.buttons_high | 8'h31;
            end
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs change on the falling edge, handshakes seen on the rising edge
    // ------------------------------------------------------------------
    task automatic send_frame(t_in_beat f);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_beat  = f;
        in_valid = 1'b1;
        do @(posedge i_clk); while (!(in_valid && o_in_ready));
        sb.note_frame(f);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [7:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // registers only change with the block idle
    task automatic apply_setting(logic [7:0] n1, logic [7:0] n2, logic [7:0] n3,
                                 logic [7:0] offset, logic [7:0] dz, logic [7:0] lim);
        drain();
        write_reg(CFG_NEUTRAL_FIRST, n1);
        write_reg(CFG_NEUTRAL_SECOND, n2);
        write_reg(CFG_NEUTRAL_SHOULDER, n3);
        write_reg(CFG_STEER_OFFSET, offset);
        write_reg(CFG_STEER_DEADZONE, dz);
        write_reg(CFG_STEER_LIMIT, lim);
    endtask

    // Random traffic: single frames, long steady holds for the auto-repeat,
    // link faults followed by mostly analog frames that may re-trigger the abort,
    // and the odd pause until the block has emptied
    task automatic random_traffic(int count);
        t_in_beat f;
        int       n;
        int       len;
        int       s;
        n = 0;
        while (n < count) begin
            s = $urandom_range(0, 19);
            if (s < 12) begin
                send_frame(random_frame());
                n++;
            end else if (s < 14) begin
                f = random_frame();
                f.link_status = 8'd0;
                if (f.pad_kind != KIND_ANALOG) f.pad_kind = KIND_DIGITAL;
                len = $urandom_range(30, 50);
                repeat (len) send_frame(f);
                n += len;
            end else if (s < 18) begin
                f = random_frame();
                f.link_status = 8'($urandom_range(1, 255));
                send_frame(f);
                len = $urandom_range(4, 40);
                repeat (len) begin
                    f = random_frame();
                    f.link_status = 8'd0;
                    if ($urandom_range(0, 3) != 0) f.pad_kind = KIND_ANALOG;
                    if ($urandom_range(0, 4) == 0) begin
                        case ($urandom_range(0, 2))
                            0: f.buttons_high = f.buttons_high & 8'hAF;
                            1: f.buttons_high = f.buttons_high & 8'h5F;
                            default: f.buttons_low = f.buttons_low & 8'hFB;
                        endcase
                    end
                    send_frame(f);
                end
                n += len + 1;
            end else begin
                drain();
                send_frame(random_frame());
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls per beat, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int gap;
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                out_ready = 1'b0;
                repeat (HOLD_OFF) @(negedge i_clk);
                long_hold = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && out_ready));
            sb.check_result(o_out_beat);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: neutrals offset from zero so the floor and thresholds show
        apply_setting(8'h10, 8'h20, 8'h30, 8'h00, 8'd4, 8'd127);
        send_frame(poll_frame(8'h00, KIND_DIGITAL, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00));
        send_frame(poll_frame(8'h00, KIND_DIGITAL, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_frame(poll_frame(8'h00, KIND_DIGITAL, 8'hDF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_frame(poll_frame(8'h00, KIND_DIGITAL, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_frame(poll_frame(8'h00, KIND_DIGITAL, 8'hFF, 8'h3B, 8'h80, 8'h00, 8'h00, 8'h00));
        // analog: floor at zero, clamp at the top, thresholds exactly and one below
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'hA3, 8'h46, 8'h56, 8'h66));
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'hA2, 8'h45, 8'h55, 8'h65));
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'h5E, 8'h10, 8'h20, 8'h30));
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'h5D, 8'h10, 8'h20, 8'h30));
        // unknown pad kinds
        send_frame(poll_frame(8'h00, KIND_NONE, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_frame(poll_frame(8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC));
        // link error, the suppressed frames, then abort combinations in the hold window
        send_frame(poll_frame(8'hFF, KIND_ANALOG, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00));
        repeat (4) send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'h80,
                                         8'h00, 8'h00, 8'h00));
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hAF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00));
        repeat (4) send_frame(poll_frame(8'h00, KIND_ANALOG, 8'hFF, 8'hFF, 8'h80,
                                         8'h00, 8'h00, 8'h00));
        send_frame(poll_frame(8'h00, KIND_ANALOG, 8'h5F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00));

        // all registers at their low extreme, steering limit zero
        apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0);
        random_traffic(PHASE_ITEMS);

        // high extremes
        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'd127, 8'd127);
        random_traffic(PHASE_ITEMS);

        // most negative centre offset; receiver holds off while the sender keeps
        // offering back to back, so both result entries fill and input ready drops
        apply_setting(8'h20, 8'h40, 8'h08, 8'h80, 8'd10, 8'd100);
        no_idle   = 1'b1;
        long_hold = 1'b1;
        random_traffic(40);
        no_idle = 1'b0;
        random_traffic(PHASE_ITEMS - 40);

        apply_setting(rbyte(), rbyte(), rbyte(), rbyte(),
                      8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
        random_traffic(PHASE_ITEMS);

        // reset values again, starting with a stretch of back-to-back beats both ways
        apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd127);
        no_idle = 1'b1;
        random_traffic(120);
        no_idle = 1'b0;
        random_traffic(PHASE_ITEMS - 120);

        apply_setting(rbyte(), rbyte(), rbyte(), rbyte(),
                      8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
        random_traffic(PHASE_ITEMS);

        // let everything drain, then a short quiet spell for any stray beat
        drain();
        repeat (20) @(negedge i_clk);
        if (sb.pending() != 0) sb.report("results still outstanding at end of run");
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== gamepad_input_conditioner.f =====
sv/gic_pkg.sv
sv/gic_frame.sv
sv/gamepad_input_conditioner.sv
sim/tb.sv
